FILE: hdl/odo_pkg.sv
package odo_pkg;

  // Datapath widths
  localparam int ACC_W  = 66;  // product accumulator, holds any signed product of the flow
  localparam int LANE_N = 4;   // multiplier lanes sharing one serial multiplier operand
  localparam int CW     = 34;  // CORDIC x, y and z width
  localparam int TAB_LEN = 24;

  // Angle units per radian in Q30, and CORDIC gain compensation in Q1.30
  localparam logic [31:0]          ANG_PER_RAD = 32'd341782638;
  localparam logic signed [CW-1:0] CORDIC_KINV = 34'sd652032874;

  // Last step index of each serial multiply (multiplier bit count minus one)
  localparam logic [5:0] LAST_CFG = 6'd23;  // 24-bit unsigned register operand
  localparam logic [5:0] LAST_ANG = 6'd28;  // 29-bit angle scale constant
  localparam logic [5:0] LAST_DS  = 6'd31;  // 32-bit signed centre arc

  typedef enum logic [1:0] {
    REG_USE_IMU = 2'd0,
    REG_MPC     = 2'd1,
    REG_IWB     = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_SET2,
    S_MUL2,
    S_SET3,
    S_MUL3,
    S_SET4,
    S_CORDIC,
    S_SET5,
    S_MUL4,
    S_DONE
  } odo_state_e;

  // atan(2^-i) in angle units where 2^32 is 2 pi
  function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [CW-1:0] r;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat_s32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
      r = v[31:0];
    end else begin
      r = v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // Saturate to signed 16 bits
  function automatic logic signed [15:0] sat_s16(input logic signed [CW-1:0] v);
    logic signed [15:0] r;
    if (v[CW-1:15] == '0 || v[CW-1:15] == '1) begin
      r = v[15:0];
    end else begin
      r = v[CW-1] ? 16'sh8000 : 16'sh7fff;
    end
    return r;
  endfunction

  // Saturate to signed 40 bits (travel difference)
  function automatic logic signed [ACC_W-1:0] sat_s40(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W-1:39] == '0 || v[ACC_W-1:39] == '1) begin
      r = v;
    end else if (v[ACC_W-1]) begin
      r = -(ACC_W'(1) <<< 39);
    end else begin
      r = (ACC_W'(1) <<< 39) - ACC_W'(1);
    end
    return r;
  endfunction

  // Clamp to [-2^33, 2^33] (turn per step)
  function automatic logic signed [ACC_W-1:0] sat_rad(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W-1]) begin
      r = (v[ACC_W-1:33] == '1) ? v : -(ACC_W'(1) <<< 33);
    end else begin
      r = (v[ACC_W-1:33] == '0) ? v : (ACC_W'(1) <<< 33);
    end
    return r;
  endfunction

endpackage

FILE: hdl/odo_if.sv
interface odo_in_if #(
  parameter int COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] left_count;
  logic [COUNT_BITS-1:0] right_count;
  logic signed [15:0]    left_rate;
  logic signed [15:0]    right_rate;
  logic signed [15:0]    imu_yaw;
  logic signed [31:0]    imu_yaw_rate;

  modport source (
    output valid, left_count, right_count, left_rate, right_rate, imu_yaw, imu_yaw_rate,
    input  ready
  );
  modport sink (
    input  valid, left_count, right_count, left_rate, right_rate, imu_yaw, imu_yaw_rate,
    output ready
  );
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading_angle;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_z;
  logic signed [31:0] lin_speed;
  logic signed [31:0] yaw_rate;

  modport source (
    output valid, pos_x, pos_y, heading_angle, quat_w, quat_z, lin_speed, yaw_rate,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, heading_angle, quat_w, quat_z, lin_speed, yaw_rate,
    output ready
  );
endinterface

FILE: hdl/differential_drive_odometry_top.sv
// Differential-drive odometry integrator.
// in_ch carries one tick of encoder counts, wheel rates and IMU yaw data per
// transaction; out_ch returns one pose transaction per input transaction.
// Configuration (heading source, metres per count, inverse wheel base) is
// written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only
// while the block is idle; the block does not enforce this. All products go
// through one bit-serial multiplier with four lanes sharing the multiplier
// operand, one bit per cycle; sin and cos come from two CORDIC lanes running
// one rotation per cycle. With wheel heading an item runs three multiply passes
// of 24, 24 and 29 bits, the CORDIC pass and a 32-bit pass, with set-up states
// between them; with IMU heading the second 24-bit pass is skipped.
// One transaction is in flight at a time; in_ch.ready is high when idle.
// The result sits in an output register, so the next input is taken while an
// unread result waits; if out_ch stalls, that next item completes and then
// holds until the output register frees.
// Reset clears pose, heading and the primed flag and restores the default
// configuration; the first item after reset only primes the previous counts.
module differential_drive_odometry_top #(
  parameter int COUNT_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  odo_in_if.sink      in_ch,
  odo_out_if.source   out_ch
);
  import odo_pkg::*;

  localparam int CI_W = $clog2(CORDIC_STEPS);
  localparam logic [CI_W-1:0] CI_LAST = CI_W'(CORDIC_STEPS - 1);
  localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF    = CW'(64'sd2147483648);

  // Configuration registers
  logic        use_imu_q;
  logic [23:0] mpc_q;
  logic [23:0] iwb_q;

  // Control and state
  odo_state_e            state_q, state_d;
  logic [COUNT_BITS-1:0] last_left_q, last_right_q;
  logic                  primed_q;
  logic [31:0]           heading_q;
  logic signed [31:0]    x_acc_q, y_acc_q;

  // Captured inputs and intermediate results
  logic signed [15:0] yaw_q;
  logic signed [31:0] yaw_rate_q;
  logic signed [31:0] ds_q, lin_q, yr_q;
  logic signed [15:0] qw_q, qz_q;

  // Serial multiplier
  logic signed [ACC_W-1:0] a_q [LANE_N];
  logic signed [ACC_W-1:0] p_q [LANE_N];
  logic signed [ACC_W-1:0] p_next [LANE_N];
  logic [31:0]             b_q;
  logic [5:0]              cnt_q, last_q;
  logic                    sgn_q;
  logic                    mul_last;

  // CORDIC lanes: lane 0 half heading (quaternion), lane 1 full heading (position)
  logic signed [CW-1:0] cx_q [2], cy_q [2], cz_q [2];
  logic                 flip_q [2];
  logic [CI_W-1:0]      ci_q;
  logic signed [CW-1:0] cx_init [2], cz_init [2];
  logic                 flip_init [2];
  logic signed [CW-1:0] c_fin [2], s_fin [2];
  logic signed [CW-1:0] atan_i;
  logic [31:0]          ang_in [2];

  // Output register
  logic               out_valid_q;
  logic signed [31:0] o_x_q, o_y_q, o_lin_q, o_yr_q;
  logic [31:0]        o_head_q;
  logic signed [15:0] o_qw_q, o_qz_q;

  logic                    in_acc, out_free;
  logic [COUNT_BITS-1:0]   dlc, drc;
  logic signed [31:0]      ds_w, lin_w, yrw_w, x_new, y_new;
  logic signed [ACC_W-1:0] dd_w, yv_w, rad_w, ang24_w, ang13_w;
  logic [31:0]             heading_new;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_q || out_ch.ready;
  assign mul_last = (cnt_q == last_q);

  // Wrapped count differences, zero on the priming item
  assign dlc = primed_q ? (in_ch.left_count - last_left_q) : '0;
  assign drc = primed_q ? (in_ch.right_count - last_right_q) : '0;

  // Post-multiply scaling
  assign ds_w    = sat_s32((p_q[0] + p_q[1]) >>> 9);
  assign lin_w   = sat_s32((p_q[2] + p_q[3]) >>> 9);
  assign dd_w    = sat_s40(p_q[1] - p_q[0]);
  assign yv_w    = (p_q[3] - p_q[2]) >>> 8;
  assign rad_w   = sat_rad(p_q[0] >>> 16);
  assign yrw_w   = sat_s32(p_q[1] >>> 16);
  assign ang24_w = p_q[0] >>> 24;
  assign ang13_w = p_q[0] >>> 13;
  assign heading_new = use_imu_q ? ang13_w[31:0] : (heading_q + ang24_w[31:0]);
  assign x_new = sat_s32(ACC_W'(x_acc_q) + (p_q[0] >>> 30));
  assign y_new = sat_s32(ACC_W'(y_acc_q) + (p_q[1] >>> 30));

  // Multiplier lane step: add shifted multiplicand, subtract on a signed top bit
  always_comb begin
    for (int k = 0; k < LANE_N; k++) begin
      if (!b_q[0]) begin
        p_next[k] = p_q[k];
      end else if (mul_last && sgn_q) begin
        p_next[k] = p_q[k] - a_q[k];
      end else begin
        p_next[k] = p_q[k] + a_q[k];
      end
    end
  end

  // CORDIC start: fold the angle into +-pi/2
  assign ang_in[0] = heading_new;
  assign ang_in[1] = {heading_new[30:0], 1'b0};
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      cx_init[k]   = CW'($signed(ang_in[k]));
      flip_init[k] = 1'b0;
      if (cx_init[k] > QUARTER) begin
        cz_init[k]   = cx_init[k] - HALF;
        flip_init[k] = 1'b1;
      end else if (cx_init[k] < -QUARTER) begin
        cz_init[k]   = cx_init[k] + HALF;
        flip_init[k] = 1'b1;
      end else begin
        cz_init[k] = cx_init[k];
      end
      c_fin[k] = flip_q[k] ? -cx_q[k] : cx_q[k];
      s_fin[k] = flip_q[k] ? -cy_q[k] : cy_q[k];
    end
  end

  assign atan_i = atan_lut(5'(ci_q));

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_imu_q <= 1'b0;
      mpc_q     <= 24'd2412;
      iwb_q     <= 24'd409600;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_USE_IMU: use_imu_q <= cfg_data_i[0];
        REG_MPC:     mpc_q     <= cfg_data_i;
        REG_IWB:     iwb_q     <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_MUL1;
      S_MUL1:   if (mul_last) state_d = S_SET2;
      S_SET2:   state_d = use_imu_q ? S_MUL3 : S_MUL2;
      S_MUL2:   if (mul_last) state_d = S_SET3;
      S_SET3:   state_d = S_MUL3;
      S_MUL3:   if (mul_last) state_d = S_SET4;
      S_SET4:   state_d = S_CORDIC;
      S_CORDIC: if (ci_q == CI_LAST) state_d = S_SET5;
      S_SET5:   state_d = S_MUL4;
      S_MUL4:   if (mul_last) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_q == S_IDLE);

  // Pose state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_left_q  <= '0;
      last_right_q <= '0;
      primed_q     <= 1'b0;
      heading_q    <= '0;
      x_acc_q      <= '0;
      y_acc_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        last_left_q  <= in_ch.left_count;
        last_right_q <= in_ch.right_count;
        primed_q     <= 1'b1;
      end
      if (state_q == S_SET4) begin
        heading_q <= heading_new;
      end
      if (state_q == S_DONE && out_free) begin
        x_acc_q     <= x_new;
        y_acc_q     <= y_new;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: multiplier lanes, CORDIC lanes, intermediate results
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          a_q[0]     <= ACC_W'($signed(dlc));
          a_q[1]     <= ACC_W'($signed(drc));
          a_q[2]     <= ACC_W'(in_ch.left_rate);
          a_q[3]     <= ACC_W'(in_ch.right_rate);
          b_q        <= {8'd0, mpc_q};
          last_q     <= LAST_CFG;
          sgn_q      <= 1'b0;
          cnt_q      <= '0;
          for (int k = 0; k < LANE_N; k++) p_q[k] <= '0;
          yaw_q      <= in_ch.imu_yaw;
          yaw_rate_q <= in_ch.imu_yaw_rate;
        end
      end
      S_MUL1, S_MUL2, S_MUL3, S_MUL4: begin
        for (int k = 0; k < LANE_N; k++) begin
          p_q[k] <= p_next[k];
          a_q[k] <= a_q[k] <<< 1;
        end
        b_q   <= b_q >> 1;
        cnt_q <= cnt_q + 6'd1;
      end
      S_SET2: begin
        ds_q  <= ds_w;
        lin_q <= lin_w;
        cnt_q <= '0;
        sgn_q <= 1'b0;
        for (int k = 0; k < LANE_N; k++) p_q[k] <= '0;
        if (use_imu_q) begin
          a_q[0] <= ACC_W'(yaw_q);
          b_q    <= ANG_PER_RAD;
          last_q <= LAST_ANG;
          yr_q   <= yaw_rate_q;
        end else begin
          a_q[0] <= dd_w;
          a_q[1] <= yv_w;
          b_q    <= {8'd0, iwb_q};
          last_q <= LAST_CFG;
        end
      end
      S_SET3: begin
        yr_q   <= yrw_w;
        a_q[0] <= rad_w;
        b_q    <= ANG_PER_RAD;
        last_q <= LAST_ANG;
        cnt_q  <= '0;
        for (int k = 0; k < LANE_N; k++) p_q[k] <= '0;
      end
      S_SET4: begin
        for (int k = 0; k < 2; k++) begin
          cx_q[k]   <= CORDIC_KINV;
          cy_q[k]   <= '0;
          cz_q[k]   <= cz_init[k];
          flip_q[k] <= flip_init[k];
        end
        ci_q <= '0;
      end
      S_CORDIC: begin
        for (int k = 0; k < 2; k++) begin
          if (!cz_q[k][CW-1]) begin
            cx_q[k] <= cx_q[k] - (cy_q[k] >>> ci_q);
            cy_q[k] <= cy_q[k] + (cx_q[k] >>> ci_q);
            cz_q[k] <= cz_q[k] - atan_i;
          end else begin
            cx_q[k] <= cx_q[k] + (cy_q[k] >>> ci_q);
            cy_q[k] <= cy_q[k] - (cx_q[k] >>> ci_q);
            cz_q[k] <= cz_q[k] + atan_i;
          end
        end
        ci_q <= ci_q + CI_W'(1);
      end
      S_SET5: begin
        qw_q   <= use_imu_q ? 16'sd0 : sat_s16(c_fin[0] >>> 15);
        qz_q   <= use_imu_q ? 16'sd0 : sat_s16(s_fin[0] >>> 15);
        a_q[0] <= ACC_W'(c_fin[1]);
        a_q[1] <= ACC_W'(s_fin[1]);
        b_q    <= ds_q;
        last_q <= LAST_DS;
        sgn_q  <= 1'b1;
        cnt_q  <= '0;
        for (int k = 0; k < LANE_N; k++) p_q[k] <= '0;
      end
      S_DONE: begin
        if (out_free) begin
          o_x_q    <= x_new;
          o_y_q    <= y_new;
          o_head_q <= heading_q;
          o_qw_q   <= qw_q;
          o_qz_q   <= qz_q;
          o_lin_q  <= lin_q;
          o_yr_q   <= yr_q;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.pos_x         = o_x_q;
  assign out_ch.pos_y         = o_y_q;
  assign out_ch.heading_angle = o_head_q;
  assign out_ch.quat_w        = o_qw_q;
  assign out_ch.quat_z        = o_qz_q;
  assign out_ch.lin_speed     = o_lin_q;
  assign out_ch.yaw_rate      = o_yr_q;

  // An accepted item always starts the first multiply pass
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_MUL1)
    else $error("accepted item did not start multiply");

  // A finished item loads the output register and frees the input side
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("finished item not delivered");

  // Step counter never passes the end of the multiply pass
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_MUL3 || state_q == S_MUL4)
    |-> cnt_q <= last_q)
    else $error("multiply step counter overran");

  // Quaternion is zero whenever heading comes from the IMU
  a_quat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && use_imu_q |-> o_qw_q == 16'sd0 && o_qz_q == 16'sd0)
    else $error("quaternion non-zero in IMU mode");

endmodule

FILE: verif/odo_tb_if.sv
`timescale 1ns / 100ps

// Interfaces come from the RTL (hdl/odo_if.sv); this file holds the shared
// result record that the predictor queues up for the pose checker.
package odo_tb_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading_angle;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic signed [31:0] lin_speed;
    logic signed [31:0] yaw_rate;
  } pose_t;

endpackage

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import odo_pkg::*;
  import odo_tb_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int DRAIN_CYCLES = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;

  odo_in_if  in_ch ();
  odo_out_if out_ch ();

  differential_drive_odometry_top #(
    .COUNT_BITS  (16),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Clock
  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // Predictor state
  logic        m_imu;
  logic [23:0] m_mpc;
  logic [23:0] m_iwb;
  logic [15:0] m_last_l, m_last_r;
  logic        m_primed;
  logic [31:0] m_heading;
  longint      m_x, m_y;

  pose_t  pose_q[$];
  int     errors;
  bit     quiet;      // no idling on either side
  bit     out_stall;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rotation by binary angle (2^32 = 2 pi), Q1.30 outputs
  task automatic rotate(input logic [31:0] angle, output longint c, output longint s);
    longint z, x, y, nx, ny;
    longint atan_v[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    bit flip;
    z = longint'($signed(angle));
    flip = 0;
    x = 652032874;
    y = 0;
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31); flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31); flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_v[i];
      end else begin
        nx = x + asr(y, i); ny = y - asr(x, i); z += atan_v[i];
      end
      x = nx; y = ny;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x; s = y;
  endtask

  // Works out the pose for one tick and advances the predictor state
  task automatic predict_pose(input logic [15:0] cl, input logic [15:0] cr,
                              input logic signed [15:0] rl, input logic signed [15:0] rr,
                              input logic signed [15:0] yaw, input logic signed [31:0] yr_in);
    longint mpc, iwb, dl, dr, ds, vl, vr, lin, yr, c, s, qw, qz, dd, rad;
    pose_t p;
    mpc = longint'(m_mpc);
    iwb = longint'(m_iwb);
    qw = 0; qz = 0;
    if (!m_primed) begin
      m_last_l = cl; m_last_r = cr; m_primed = 1;
    end
    dl = longint'($signed(16'(cl - m_last_l))) * mpc;
    dr = longint'($signed(16'(cr - m_last_r))) * mpc;
    m_last_l = cl; m_last_r = cr;
    ds = clamp(asr(asr(dl + dr, 1), 8), -64'sd2147483648, 64'sd2147483647);
    vl = longint'(rl) * mpc;
    vr = longint'(rr) * mpc;
    lin = clamp(asr(vl + vr, 9), -64'sd2147483648, 64'sd2147483647);
    if (m_imu) begin
      m_heading = 32'(asr(longint'(yaw) * 341782638, 13));
      yr = longint'(yr_in);
    end else begin
      dd = clamp(dr - dl, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
      rad = clamp(asr(dd * iwb, 16), -(64'sd1 <<< 33), 64'sd1 <<< 33);
      m_heading = m_heading + 32'(asr(rad * 341782638, 24));
      yr = clamp(asr(asr(vr - vl, 8) * iwb, 16), -64'sd2147483648, 64'sd2147483647);
      rotate(m_heading, c, s);
      qw = clamp(asr(c, 15), -32768, 32767);
      qz = clamp(asr(s, 15), -32768, 32767);
    end
    rotate({m_heading[30:0], 1'b0}, c, s);
    m_x = clamp(m_x + asr(ds * c, 30), -64'sd2147483648, 64'sd2147483647);
    m_y = clamp(m_y + asr(ds * s, 30), -64'sd2147483648, 64'sd2147483647);
    p.pos_x = 32'(m_x);
    p.pos_y = 32'(m_y);
    p.heading_angle = m_heading;
    p.quat_w = 16'(qw);
    p.quat_z = 16'(qz);
    p.lin_speed = 32'(lin);
    p.yaw_rate = 32'(yr);
    pose_q.push_back(p);
  endtask

  // Sends one tick; the prediction is made at acceptance
  task automatic send_tick(input logic [15:0] cl, input logic [15:0] cr,
                           input logic [15:0] rl, input logic [15:0] rr,
                           input logic [15:0] yaw, input logic [31:0] yr);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_count   <= cl;
    in_ch.right_count  <= cr;
    in_ch.left_rate    <= rl;
    in_ch.right_rate   <= rr;
    in_ch.imu_yaw      <= yaw;
    in_ch.imu_yaw_rate <= yr;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_pose(cl, cr, rl, rr, yaw, yr);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_poses();
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write while idle; the predictor follows it
  task automatic write_reg(input reg_idx_e idx, input logic [23:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_USE_IMU: m_imu = val[0];
      REG_MPC:     m_mpc = val;
      REG_IWB:     m_iwb = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom());
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    pose_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pos_x, out_ch.pos_y, out_ch.heading_angle, out_ch.quat_w,
              out_ch.quat_z, out_ch.lin_speed, out_ch.yaw_rate};
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected pose transaction %h", $time, got);
        errors++;
      end else begin
        want = pose_q.pop_front();
        if (got.pos_x !== want.pos_x)
          $display("%0t: pos_x exp %h got %h", $time, want.pos_x, got.pos_x);
        if (got.pos_y !== want.pos_y)
          $display("%0t: pos_y exp %h got %h", $time, want.pos_y, got.pos_y);
        if (got.heading_angle !== want.heading_angle)
          $display("%0t: heading exp %h got %h", $time, want.heading_angle,
                   got.heading_angle);
        if (got.quat_w !== want.quat_w)
          $display("%0t: quat_w exp %h got %h", $time, want.quat_w, got.quat_w);
        if (got.quat_z !== want.quat_z)
          $display("%0t: quat_z exp %h got %h", $time, want.quat_z, got.quat_z);
        if (got.lin_speed !== want.lin_speed)
          $display("%0t: lin_speed exp %h got %h", $time, want.lin_speed,
                   got.lin_speed);
        if (got.yaw_rate !== want.yaw_rate)
          $display("%0t: yaw_rate exp %h got %h", $time, want.yaw_rate, got.yaw_rate);
        if (got !== want) errors++;
      end
    end
  end

  // Receiver stalls in bursts
  always @(posedge clk_i) begin
    int burst;
    if (quiet || !rst_ni) begin
      out_ch.ready <= 1'b1;
    end else if (out_stall) begin
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 14);
      out_stall = 1;
      out_ch.ready <= 1'b0;
      fork
        begin
          repeat (burst) @(posedge clk_i);
          out_stall = 0;
        end
      join_none
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Directed: priming, count extremes and wrap, rate extremes
  task automatic test_wheel_extremes();
    send_tick(16'hfff0, 16'h0010, 16'h7fff, 16'h8000, 16'h0, 32'h0);
    send_tick(16'h0010, 16'hfff0, 16'h8000, 16'h7fff, 16'hffff, 32'hffffffff);
    send_tick(16'h8010, 16'h8000, 16'h0, 16'h0, 16'h0, 32'h0);   // half-range jump
    send_tick(16'h0011, 16'h7fff, 16'hffff, 16'h0001, 16'h0, 32'h0);
    send_tick(16'h0011, 16'h7fff, 16'h0, 16'h0, 16'h0, 32'h0);   // no motion
    send_tick(16'h0000, 16'hffff, 16'h0, 16'h0, 16'h0, 32'h0);
    drain_poses();
  endtask

  // Directed: large scales drive every saturation point
  task automatic test_saturation();
    write_reg(REG_MPC, 24'hffffff);
    write_reg(REG_IWB, 24'hffffff);
    for (int i = 0; i < 6; i++)
      send_tick(16'(i * 16'h7fff), 16'(i * 16'h4000), 16'h7fff, 16'h8000,
                16'h0, 32'h0);
    for (int i = 0; i < 40; i++)   // straight run until position saturates
      send_tick(16'(i * 16'h7000), 16'(i * 16'h7000), 16'h7fff, 16'h7fff,
                16'h0, 32'h0);
    drain_poses();
    write_reg(REG_MPC, 24'h0);
    write_reg(REG_IWB, 24'h0);
    send_tick(16'h1234, 16'h4321, 16'h7fff, 16'h8000, 16'h0, 32'h0);
    drain_poses();
  endtask

  // Directed: IMU heading extremes
  task automatic test_imu_heading();
    write_reg(REG_USE_IMU, 24'h1);
    write_reg(REG_MPC, 24'd2412);
    write_reg(REG_IWB, 24'd409600);
    send_tick(16'h0100, 16'h0200, 16'h0100, 16'h0100, 16'h7fff, 32'h7fffffff);
    send_tick(16'h0200, 16'h0300, 16'h0100, 16'h0100, 16'h8000, 32'h80000000);
    send_tick(16'h0300, 16'h0400, 16'h0, 16'h0, 16'h5555, 32'h55555555);
    send_tick(16'h0400, 16'h0500, 16'h0, 16'h0, 16'haaaa, 32'haaaaaaaa);
    drain_poses();
  endtask

  // Random: mostly small steps, some wide jumps; idling while in phases
  task automatic test_random(input int n);
    logic [15:0] cl, cr;
    cl = rnd16();
    cr = rnd16();
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        drain_poses();
        write_reg(REG_USE_IMU, 24'($urandom_range(0, 1)));
        write_reg(REG_MPC, ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                                       : 24'($urandom_range(0, 8000)));
        write_reg(REG_IWB, ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                                       : 24'($urandom_range(0, 800000)));
        if (n - i <= 200) quiet = 1;
      end
      if ($urandom_range(0, 9) == 0) begin
        cl = rnd16(); cr = rnd16();
      end else begin
        cl += 16'($urandom_range(0, 200) - 100);
        cr += 16'($urandom_range(0, 200) - 100);
      end
      send_tick(cl, cr, rnd16(), rnd16(), rnd16(), $urandom());
      if (i == n / 3) begin
        while (pose_q.size() != 0) @(posedge clk_i);  // sender hold-off
      end
    end
  endtask

  initial begin
    errors = 0; quiet = 0; out_stall = 0;
    m_imu = 0; m_mpc = 24'd2412; m_iwb = 24'd409600;
    m_last_l = 0; m_last_r = 0; m_primed = 0; m_heading = 0; m_x = 0; m_y = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = REG_USE_IMU; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.left_count = '0; in_ch.right_count = '0;
    in_ch.left_rate = '0; in_ch.right_rate = '0; in_ch.imu_yaw = '0;
    in_ch.imu_yaw_rate = '0;
    out_ch.ready = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_wheel_extremes();
    test_saturation();
    test_imu_heading();
    test_random(1600);
    drain_poses();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/odo_pkg.sv
hdl/odo_if.sv
hdl/differential_drive_odometry_top.sv
verif/odo_tb_if.sv
verif/tb.sv
